>>> src/jtw_pkg.sv
// Shared types, codes and byte tables for the JSON token writer.
package jtw_pkg;

    localparam int DEF_MAX_DEPTH = 8;
    localparam int INDENT_CAP    = 32;
    localparam int SPC_W         = 6;
    localparam int IDX_W         = 3;

    typedef enum logic [3:0] {
        A_OBJ_BEGIN = 4'd0,
        A_OBJ_END   = 4'd1,
        A_ARR_BEGIN = 4'd2,
        A_ARR_END   = 4'd3,
        A_STR_BEGIN = 4'd4,
        A_STR_CHAR  = 4'd5,
        A_STR_END   = 4'd6,
        A_NULL      = 4'd7,
        A_TRUE      = 4'd8,
        A_FALSE     = 4'd9,
        A_RAW_CHAR  = 4'd10,
        A_RAW_END   = 4'd11
    } t_action;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_KEY_POS = 3'd1,
        ST_BAD_OBJ = 3'd2,
        ST_BAD_ARR = 3'd3,
        ST_OVERFLOW = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        SM_NONE = 2'd0,
        SM_VALUE = 2'd1,
        SM_KEY  = 2'd2,
        SM_RAW  = 2'd3
    } t_smode;

    typedef enum logic [2:0] {
        R_USES_NEWLINE  = 3'd0,
        R_OBJ_NEW_LINE  = 3'd1,
        R_ARR_NEW_LINE  = 3'd2,
        R_INDENT_WIDTH  = 3'd3,
        R_LEFT_SPACING  = 3'd4,
        R_RIGHT_SPACING = 3'd5,
        R_RIGHT_COMMA   = 3'd6,
        R_LINE_END      = 3'd7
    } t_cfg_reg;

    // Body of a token: the bytes written after any separator prefix
    typedef enum logic [3:0] {
        B_NONE,
        B_LBRACE,
        B_RBRACE,
        B_LBRACK,
        B_RBRACK,
        B_QUOTE,
        B_KEY_END,
        B_NULL,
        B_TRUE,
        B_FALSE,
        B_DATA,
        B_ESC
    } t_body;

    // Byte source for one emit command
    typedef enum logic [2:0] {
        E_NONE,
        E_LINE_END,
        E_SPACE,
        E_COMMA,
        E_RCOMMA,
        E_RSPACE,
        E_BODY
    } t_emit;

    // State update applied when an item finishes
    typedef enum logic [2:0] {
        C_NONE,
        C_OPEN_OBJ,
        C_OPEN_ARR,
        C_CLOSE,
        C_KEY_BEGIN,
        C_STR_BEGIN,
        C_KEY_END,
        C_VAL_END
    } t_op;

    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_U      = 8'h75;

    typedef struct packed {
        logic          load;
        t_emit         emit;
        t_body         body;
        logic [IDX_W-1:0] idx;
        logic          ind_load;
        logic          ind_dec;
        logic          finish;
        t_status       status;
        t_op           op;
    } t_dp_cmd;

    typedef struct packed {
        t_action action;
        t_smode  smode;
        logic    top_obj;
        logic    top_arr;
        logic    obj_at_value;
        logic    full;
        logic    not_empty;
        logic    need_nl;
        logic    need_comma;
        logic    need_rsp;
        logic    uses_nl;
        logic    obj_nl;
        logic    arr_nl;
        logic    body_last;
        logic    spc_zero;
        logic    out_free;
    } t_dp_stat;

    function automatic logic [7:0] hex_digit(input logic [3:0] d);
        logic [7:0] r;
        if (d < 4'd10)
            r = 8'h30 + {4'd0, d};
        else
            r = 8'h57 + {4'd0, d};
        return r;
    endfunction

    function automatic logic [2:0] esc_len(input logic [7:0] c);
        logic [2:0] n;
        case (c)
            8'h5C, 8'h22, 8'h0A, 8'h09, 8'h08, 8'h0C, 8'h0D: n = 3'd2;
            default: n = (c < 8'h20 || c == 8'h7F) ? 3'd6 : 3'd1;
        endcase
        return n;
    endfunction

    function automatic logic [7:0] esc_byte(input logic [7:0] c, input logic [IDX_W-1:0] idx);
        logic [2:0] n;
        logic [7:0] r;
        n = esc_len(c);
        if (n == 3'd1) begin
            r = c;
        end else if (idx == '0) begin
            r = CH_BSLASH;
        end else if (n == 3'd2) begin
            case (c)
                8'h0A:   r = 8'h6E;
                8'h09:   r = 8'h74;
                8'h08:   r = 8'h62;
                8'h0C:   r = 8'h66;
                8'h0D:   r = 8'h72;
                default: r = c;      // backslash and quote repeat themselves
            endcase
        end else begin
            case (idx)
                3'd1:    r = CH_U;
                3'd4:    r = hex_digit(c[7:4]);
                3'd5:    r = hex_digit(c[3:0]);
                default: r = CH_ZERO;
            endcase
        end
        return r;
    endfunction

    function automatic logic [2:0] body_len(input t_body k, input logic [7:0] c);
        logic [2:0] n;
        case (k)
            B_NONE:               n = 3'd0;
            B_KEY_END:            n = 3'd3;
            B_NULL, B_TRUE:       n = 3'd4;
            B_FALSE:              n = 3'd5;
            B_ESC:                n = esc_len(c);
            default:              n = 3'd1;
        endcase
        return n;
    endfunction

    function automatic logic [7:0] body_byte(input t_body k, input logic [IDX_W-1:0] idx,
                                             input logic [7:0] c, input logic [7:0] lsp);
        logic [7:0] r;
        r = 8'h00;
        case (k)
            B_LBRACE: r = CH_LBRACE;
            B_RBRACE: r = CH_RBRACE;
            B_LBRACK: r = CH_LBRACK;
            B_RBRACK: r = CH_RBRACK;
            B_QUOTE:  r = CH_QUOTE;
            B_KEY_END: begin
                case (idx)
                    3'd0:    r = CH_QUOTE;
                    3'd1:    r = lsp;
                    default: r = CH_COLON;
                endcase
            end
            B_NULL: begin
                case (idx)
                    3'd0:    r = 8'h6E;
                    3'd1:    r = 8'h75;
                    default: r = 8'h6C;
                endcase
            end
            B_TRUE: begin
                case (idx)
                    3'd0:    r = 8'h74;
                    3'd1:    r = 8'h72;
                    3'd2:    r = 8'h75;
                    default: r = 8'h65;
                endcase
            end
            B_FALSE: begin
                case (idx)
                    3'd0:    r = 8'h66;
                    3'd1:    r = 8'h61;
                    3'd2:    r = 8'h6C;
                    3'd3:    r = 8'h73;
                    default: r = 8'h65;
                endcase
            end
            B_DATA:   r = c;
            B_ESC:    r = esc_byte(c, idx);
            default:  r = 8'h00;
        endcase
        return r;
    endfunction

endpackage

>>> src/jtw_datapath.sv
// Datapath: config registers, nesting stack, writer flags, indent counter, output stage.
module jtw_datapath import jtw_pkg::*; #(
    parameter int MAX_DEPTH = DEF_MAX_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_dp_cmd     i_cmd,
    output t_dp_stat    o_stat,
    input  logic [15:0] i_s_tdata,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [7:0]  i_cfg_data,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,
    output logic        o_m_tlast,
    output logic        o_m_tuser
);

    localparam int DW = $clog2(MAX_DEPTH + 1);
    localparam int AW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

    // configuration
    logic       r_uses_nl, r_obj_nl, r_arr_nl;
    logic [2:0] r_indent_w;
    logic [7:0] r_lsp, r_rsp, r_rcomma, r_line_end;

    // writer state
    logic [MAX_DEPTH-1:0] r_stack;
    logic [DW-1:0]        r_depth;
    logic                 r_need_comma, r_need_rsp, r_need_nl, r_oav, r_not_empty;
    t_smode               r_smode;

    // current item
    t_action    r_action;
    logic [7:0] r_data;

    logic [SPC_W-1:0] r_spc;

    // one byte held back so that the final one can carry last
    logic       r_pend_valid;
    logic [7:0] r_pend;

    logic       r_out_valid, r_out_bv, r_out_last;
    logic [7:0] r_out_byte;
    t_status    r_out_status;

    logic [DW-1:0]   top_ptr, lvl;
    logic [AW-1:0]   top_idx, wr_idx;
    logic            top_kind;
    logic [DW+2:0]   prod;
    logic [SPC_W-1:0] n_spc;
    logic [7:0]      e_byte;
    logic            e_skip, do_emit, out_free;

    assign top_ptr  = r_depth - DW'(1);
    assign top_idx  = top_ptr[AW-1:0];
    assign wr_idx   = r_depth[AW-1:0];
    assign top_kind = r_stack[top_idx];
    assign out_free = !r_out_valid || i_m_tready;

    // indent length: level times width, saturated
    assign lvl   = i_cmd.ind_dec ? top_ptr : r_depth;
    assign prod  = (DW+3)'(lvl) * (DW+3)'(r_indent_w);
    assign n_spc = (prod > (DW+3)'(INDENT_CAP)) ? SPC_W'(INDENT_CAP) : SPC_W'(prod);

    always_comb begin
        e_byte = 8'h00;
        e_skip = 1'b0;
        case (i_cmd.emit)
            E_LINE_END: begin
                e_byte = r_line_end;
                e_skip = (r_line_end == 8'h00);
            end
            E_SPACE:  e_byte = CH_SPACE;
            E_COMMA:  e_byte = CH_COMMA;
            E_RCOMMA: begin
                e_byte = r_rcomma;
                e_skip = (r_rcomma == 8'h00);
            end
            E_RSPACE: begin
                e_byte = r_rsp;
                e_skip = (r_rsp == 8'h00);
            end
            E_BODY: begin
                e_byte = body_byte(i_cmd.body, i_cmd.idx, r_data, r_lsp);
                e_skip = (i_cmd.body == B_KEY_END) && (i_cmd.idx == IDX_W'(1))
                         && (r_lsp == 8'h00);
            end
            default: e_skip = 1'b1;
        endcase
    end

    assign do_emit = (i_cmd.emit != E_NONE) && !e_skip;

    always_comb begin
        o_stat.action       = r_action;
        o_stat.smode        = r_smode;
        o_stat.top_obj      = (r_depth != '0) && !top_kind;
        o_stat.top_arr      = (r_depth != '0) && top_kind;
        o_stat.obj_at_value = r_oav;
        o_stat.full         = (r_depth >= DW'(MAX_DEPTH));
        o_stat.not_empty    = r_not_empty;
        o_stat.need_nl      = r_need_nl;
        o_stat.need_comma   = r_need_comma;
        o_stat.need_rsp     = r_need_rsp;
        o_stat.uses_nl      = r_uses_nl;
        o_stat.obj_nl       = r_obj_nl;
        o_stat.arr_nl       = r_arr_nl;
        o_stat.body_last    = ({1'b0, i_cmd.idx} + 4'd1) == {1'b0, body_len(i_cmd.body, r_data)};
        o_stat.spc_zero     = (r_spc == '0);
        o_stat.out_free     = out_free;
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_uses_nl  <= 1'b1;
            r_obj_nl   <= 1'b0;
            r_arr_nl   <= 1'b0;
            r_indent_w <= 3'd4;
            r_lsp      <= 8'h00;
            r_rsp      <= 8'h20;
            r_rcomma   <= 8'h20;
            r_line_end <= 8'h0A;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_idx))
                R_USES_NEWLINE:  r_uses_nl  <= i_cfg_data[0];
                R_OBJ_NEW_LINE:  r_obj_nl   <= i_cfg_data[0];
                R_ARR_NEW_LINE:  r_arr_nl   <= i_cfg_data[0];
                R_INDENT_WIDTH:  r_indent_w <= i_cfg_data[2:0];
                R_LEFT_SPACING:  r_lsp      <= i_cfg_data;
                R_RIGHT_SPACING: r_rsp      <= i_cfg_data;
                R_RIGHT_COMMA:   r_rcomma   <= i_cfg_data;
                R_LINE_END:      r_line_end <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // item latch and nesting stack (stack entries are written before read)
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action <= t_action'(i_s_tdata[3:0]);
            r_data   <= i_s_tdata[11:4];
        end
        if (i_cmd.finish && (i_cmd.op == C_OPEN_OBJ || i_cmd.op == C_OPEN_ARR))
            r_stack[wr_idx] <= (i_cmd.op == C_OPEN_ARR);
    end

    // writer flags, updated once per item when it finishes; indent counter loaded and counted down per space
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth      <= '0;
            r_need_comma <= 1'b0;
            r_need_rsp   <= 1'b0;
            r_need_nl    <= 1'b0;
            r_oav        <= 1'b0;
            r_not_empty  <= 1'b0;
            r_smode      <= SM_NONE;
            r_spc        <= '0;
        end else begin
            if (i_cmd.ind_load)
                r_spc <= n_spc;
            else if (i_cmd.emit == E_SPACE)
                r_spc <= r_spc - SPC_W'(1);
            if (i_cmd.finish) begin
                case (i_cmd.op)
                    C_OPEN_OBJ, C_OPEN_ARR: begin
                        r_depth      <= r_depth + DW'(1);
                        r_not_empty  <= 1'b0;
                        r_need_nl    <= r_uses_nl;
                        r_need_comma <= 1'b0;
                        r_need_rsp   <= 1'b0;
                        if (i_cmd.op == C_OPEN_OBJ)
                            r_oav <= 1'b0;
                    end
                    C_CLOSE: begin
                        r_depth      <= top_ptr;
                        r_need_nl    <= 1'b0;
                        r_need_comma <= 1'b1;
                        r_oav        <= 1'b0;
                        r_not_empty  <= 1'b1;
                    end
                    C_KEY_BEGIN: begin
                        r_need_nl    <= 1'b0;
                        r_need_comma <= 1'b0;
                        r_smode      <= SM_KEY;
                    end
                    C_STR_BEGIN: begin
                        r_need_nl    <= 1'b0;
                        r_need_comma <= 1'b0;
                        r_need_rsp   <= 1'b0;
                        r_smode      <= (r_action == A_RAW_CHAR) ? SM_RAW : SM_VALUE;
                    end
                    C_KEY_END: begin
                        r_need_rsp <= 1'b1;
                        r_oav      <= 1'b1;
                        r_smode    <= SM_NONE;
                    end
                    C_VAL_END: begin
                        r_need_nl    <= 1'b0;
                        r_need_rsp   <= 1'b0;
                        r_need_comma <= 1'b1;
                        r_oav        <= 1'b0;
                        r_not_empty  <= 1'b1;
                        r_smode      <= SM_NONE;
                    end
                    default: ;
                endcase
            end
        end
    end

    // pending byte and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (r_out_valid && i_m_tready)
                r_out_valid <= 1'b0;
            if (do_emit) begin
                if (r_pend_valid) begin
                    r_out_valid  <= 1'b1;
                    r_out_byte   <= r_pend;
                    r_out_bv     <= 1'b1;
                    r_out_last   <= 1'b0;
                    r_out_status <= ST_OK;
                end
                r_pend       <= e_byte;
                r_pend_valid <= 1'b1;
            end
            if (i_cmd.finish) begin
                r_out_valid  <= 1'b1;
                r_out_last   <= 1'b1;
                r_out_bv     <= r_pend_valid;
                r_out_byte   <= r_pend_valid ? r_pend : 8'h00;
                r_out_status <= r_pend_valid ? ST_OK : i_cmd.status;
                r_pend_valid <= 1'b0;
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {5'd0, r_out_status, r_out_byte};
    assign o_m_tlast  = r_out_last;
    assign o_m_tuser  = r_out_bv;

endmodule

>>> src/jtw_ctrl.sv
// Controller: decodes a token and sequences separator, indent and body bytes.
module jtw_ctrl import jtw_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_s_tvalid,
    output logic     o_s_tready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DEC,
        S_NL,
        S_COMMA,
        S_COMMA2,
        S_RSP,
        S_CLOSE_NL,
        S_IND_END,
        S_IND_SP,
        S_BODY,
        S_FIN
    } t_state;

    t_state r_state, n_state, r_ret, n_ret;
    t_body  r_body, n_body;
    t_op    r_op, n_op;
    t_status r_status, n_status;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic r_pre_nl, n_pre_nl, r_pre_comma, n_pre_comma, r_pre_rsp, n_pre_rsp;
    logic r_rsp_nl, n_rsp_nl, r_close_nl, n_close_nl, r_ind_dec, n_ind_dec;

    logic at_key, adv;

    assign at_key     = i_stat.top_obj && !i_stat.obj_at_value;
    assign adv        = i_stat.out_free;
    assign o_s_tready = (r_state == S_IDLE);

    always_comb begin
        n_state     = r_state;
        n_ret       = r_ret;
        n_body      = r_body;
        n_op        = r_op;
        n_status    = r_status;
        n_idx       = r_idx;
        n_pre_nl    = r_pre_nl;
        n_pre_comma = r_pre_comma;
        n_pre_rsp   = r_pre_rsp;
        n_rsp_nl    = r_rsp_nl;
        n_close_nl  = r_close_nl;
        n_ind_dec   = r_ind_dec;

        o_cmd         = '0;
        o_cmd.body    = r_body;
        o_cmd.idx     = r_idx;
        o_cmd.ind_dec = r_ind_dec;
        o_cmd.status  = r_status;
        o_cmd.op      = r_op;

        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DEC;
                end
            end
            S_DEC: begin
                n_body      = B_NONE;
                n_op        = C_NONE;
                n_status    = ST_OK;
                n_idx       = '0;
                n_pre_nl    = 1'b0;
                n_pre_comma = 1'b0;
                n_pre_rsp   = 1'b0;
                n_rsp_nl    = 1'b0;
                n_close_nl  = 1'b0;
                n_ind_dec   = 1'b0;
                n_state     = S_NL;
                if (i_stat.smode == SM_VALUE || i_stat.smode == SM_KEY) begin
                    if (i_stat.action == A_STR_CHAR) begin
                        n_body = B_ESC;
                    end else if (i_stat.action == A_STR_END) begin
                        n_body = (i_stat.smode == SM_KEY) ? B_KEY_END : B_QUOTE;
                        n_op   = (i_stat.smode == SM_KEY) ? C_KEY_END : C_VAL_END;
                    end
                end else if (i_stat.smode == SM_RAW) begin
                    if (i_stat.action == A_RAW_CHAR)
                        n_body = B_DATA;
                    else if (i_stat.action == A_RAW_END)
                        n_op = C_VAL_END;
                end else begin
                    case (i_stat.action)
                        A_OBJ_BEGIN, A_ARR_BEGIN: begin
                            if (at_key) begin
                                n_status = ST_KEY_POS;
                            end else if (i_stat.full) begin
                                n_status = ST_OVERFLOW;
                            end else begin
                                n_pre_nl    = 1'b1;
                                n_pre_comma = 1'b1;
                                n_pre_rsp   = 1'b1;
                                if (i_stat.action == A_OBJ_BEGIN) begin
                                    n_rsp_nl = i_stat.uses_nl && i_stat.obj_nl;
                                    n_body   = B_LBRACE;
                                    n_op     = C_OPEN_OBJ;
                                end else begin
                                    n_rsp_nl = i_stat.uses_nl && i_stat.arr_nl;
                                    n_body   = B_LBRACK;
                                    n_op     = C_OPEN_ARR;
                                end
                            end
                        end
                        A_OBJ_END: begin
                            if (!i_stat.top_obj || i_stat.obj_at_value) begin
                                n_status = ST_BAD_OBJ;
                            end else begin
                                n_close_nl = i_stat.not_empty && i_stat.uses_nl;
                                n_ind_dec  = 1'b1;
                                n_body     = B_RBRACE;
                                n_op       = C_CLOSE;
                            end
                        end
                        A_ARR_END: begin
                            if (!i_stat.top_arr) begin
                                n_status = ST_BAD_ARR;
                            end else begin
                                n_close_nl = i_stat.not_empty && i_stat.uses_nl;
                                n_ind_dec  = 1'b1;
                                n_body     = B_RBRACK;
                                n_op       = C_CLOSE;
                            end
                        end
                        A_STR_BEGIN: begin
                            n_pre_nl    = 1'b1;
                            n_pre_comma = 1'b1;
                            n_pre_rsp   = !at_key;
                            n_body      = B_QUOTE;
                            n_op        = at_key ? C_KEY_BEGIN : C_STR_BEGIN;
                        end
                        A_NULL, A_TRUE, A_FALSE, A_RAW_CHAR, A_RAW_END: begin
                            if (at_key) begin
                                n_status = ST_KEY_POS;
                            end else begin
                                n_pre_nl    = 1'b1;
                                n_pre_comma = 1'b1;
                                n_pre_rsp   = 1'b1;
                                case (i_stat.action)
                                    A_NULL: begin
                                        n_body = B_NULL;
                                        n_op   = C_VAL_END;
                                    end
                                    A_TRUE: begin
                                        n_body = B_TRUE;
                                        n_op   = C_VAL_END;
                                    end
                                    A_FALSE: begin
                                        n_body = B_FALSE;
                                        n_op   = C_VAL_END;
                                    end
                                    A_RAW_CHAR: begin
                                        n_body = B_DATA;
                                        n_op   = C_STR_BEGIN;
                                    end
                                    default: n_op = C_VAL_END;
                                endcase
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_NL: begin
                if (adv) begin
                    if (r_pre_nl && i_stat.need_nl) begin
                        n_ret   = S_COMMA;
                        n_state = S_IND_END;
                    end else begin
                        n_state = S_COMMA;
                    end
                end
            end
            S_COMMA: begin
                if (adv) begin
                    if (r_pre_comma && i_stat.need_comma) begin
                        o_cmd.emit = E_COMMA;
                        n_state    = S_COMMA2;
                    end else begin
                        n_state = S_RSP;
                    end
                end
            end
            S_COMMA2: begin
                if (adv) begin
                    if (i_stat.uses_nl) begin
                        n_ret   = S_RSP;
                        n_state = S_IND_END;
                    end else begin
                        o_cmd.emit = E_RCOMMA;
                        n_state    = S_RSP;
                    end
                end
            end
            S_RSP: begin
                if (adv) begin
                    if (r_pre_rsp && i_stat.need_rsp && r_rsp_nl) begin
                        n_ret   = S_CLOSE_NL;
                        n_state = S_IND_END;
                    end else begin
                        if (r_pre_rsp && i_stat.need_rsp)
                            o_cmd.emit = E_RSPACE;
                        n_state = S_CLOSE_NL;
                    end
                end
            end
            S_CLOSE_NL: begin
                if (adv) begin
                    if (r_close_nl) begin
                        n_ret   = S_BODY;
                        n_state = S_IND_END;
                    end else begin
                        n_state = S_BODY;
                    end
                end
            end
            S_IND_END: begin
                if (adv) begin
                    o_cmd.emit     = E_LINE_END;
                    o_cmd.ind_load = 1'b1;
                    n_state        = S_IND_SP;
                end
            end
            S_IND_SP: begin
                if (adv) begin
                    if (i_stat.spc_zero)
                        n_state = r_ret;
                    else
                        o_cmd.emit = E_SPACE;
                end
            end
            S_BODY: begin
                if (adv) begin
                    if (r_body == B_NONE) begin
                        n_state = S_FIN;
                    end else begin
                        o_cmd.emit = E_BODY;
                        if (i_stat.body_last)
                            n_state = S_FIN;
                        else
                            n_idx = r_idx + IDX_W'(1);
                    end
                end
            end
            S_FIN: begin
                if (adv) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ret       <= S_IDLE;
            r_body      <= B_NONE;
            r_op        <= C_NONE;
            r_status    <= ST_OK;
            r_idx       <= '0;
            r_pre_nl    <= 1'b0;
            r_pre_comma <= 1'b0;
            r_pre_rsp   <= 1'b0;
            r_rsp_nl    <= 1'b0;
            r_close_nl  <= 1'b0;
            r_ind_dec   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ret       <= n_ret;
            r_body      <= n_body;
            r_op        <= n_op;
            r_status    <= n_status;
            r_idx       <= n_idx;
            r_pre_nl    <= n_pre_nl;
            r_pre_comma <= n_pre_comma;
            r_pre_rsp   <= n_pre_rsp;
            r_rsp_nl    <= n_rsp_nl;
            r_close_nl  <= n_close_nl;
            r_ind_dec   <= n_ind_dec;
        end
    end

endmodule

>>> src/json_token_writer.sv
// JSON token writer top level: one token per input transfer, at most one output byte per result.
// The single byte sequencer in the controller takes a new item only once the last one is
// finished, and walks one byte per cycle while the output register is free to accept it.
// Reset (synchronous, i_rst_n low) restores the register defaults and the root state.
module json_token_writer import jtw_pkg::*; #(
    parameter int MAX_DEPTH = DEF_MAX_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave side: [3:0] action, [11:4] data_byte, [15:12] zero
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,
    // master side: [7:0] out_byte, [10:8] status, [15:11] zero
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,
    output logic        o_m_tlast,
    // master side user bits: [0] byte_valid
    output logic        o_m_tuser,
    // configuration write port
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [7:0]  i_cfg_data
);

    // Controller decides what to write; datapath holds the writer state, configuration and the output register.
    t_dp_cmd  cmd;
    t_dp_stat stat;

    jtw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // Bytes pass through a one-deep hold stage so the final byte can carry tlast;
    // the output register decouples the master side from the sequencer.
    jtw_datapath #(
        .MAX_DEPTH (MAX_DEPTH)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .i_s_tdata  (i_s_tdata),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .o_m_tuser  (o_m_tuser)
    );

endmodule

>>> src/jtw_checker.sv
// Port-level checker for the JSON token writer, bound to the top level.
module jtw_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_m_tvalid,
    input logic        i_m_tready,
    input logic [15:0] i_m_tdata,
    input logic        i_m_tlast,
    input logic        i_m_tuser
);

    // a stalled transfer holds its payload
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && !i_m_tready |=> i_m_tvalid && $stable(i_m_tdata) && $stable(i_m_tlast))
        else $error("output changed while stalled");

    // a result without a byte is always the only, hence last, result of its item
    a_empty_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && !i_m_tuser |-> i_m_tlast && (i_m_tdata[7:0] == 8'h00))
        else $error("empty result not marked last or byte not zero");

    // an error status never comes with a byte
    a_err_nobyte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && (i_m_tdata[10:8] != 3'd0) |-> !i_m_tuser)
        else $error("error status on a byte result");

    // status codes stay in range and padding stays zero
    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid |-> (i_m_tdata[10:8] <= 3'd4) && (i_m_tdata[15:11] == 5'd0))
        else $error("status out of range");

endmodule

bind json_token_writer jtw_checker u_jtw_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .i_m_tdata  (o_m_tdata),
    .i_m_tlast  (o_m_tlast),
    .i_m_tuser  (o_m_tuser)
);
